/* sv/ame_pkg.sv */
// shared types, codes and helper functions for the accumulator machine executor
// no dependencies; imported by ame_mem, ame_alu and accumulator_machine_execute_top
package ame_pkg;

   // default sizes, used as parameter defaults on the top level
   localparam int MEM_BYTES_DEF  = 4096;
   localparam int MAX_STRING_DEF = 32;

   // instruction word that halts the machine
   localparam logic [15:0] HALT_WORD = 16'h8000;

   // request kinds carried in req_tuser
   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_EXEC  = 1'b1
   } req_kind_type;

   // result kinds carried in rsp_tuser
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_NUM  = 2'd1,
      KIND_CHAR = 2'd2,
      KIND_HALT = 2'd3
   } kind_type;

   // opcodes that do something; every other code is a no-op
   typedef enum logic [3:0] {
      OP_LDA = 4'h1,
      OP_STA = 4'h2,
      OP_ADD = 4'h3,
      OP_SUB = 4'h4,
      OP_MUL = 4'h7,
      OP_PRT = 4'hB,
      OP_PRC = 4'hC,
      OP_PRS = 4'hD
   } opcode_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EXEC,
      ST_STR_RD,
      ST_STR_CHK,
      ST_EMIT
   } state_type;

   // memory port control from the sequencer
   typedef struct packed {
      logic rd;
      logic we_even;
      logic we_odd;
   } mem_ctl_type;

   // accumulator update control from the sequencer
   typedef struct packed {
      logic ld;
      logic add;
      logic sub;
      logic mul;
   } alu_ctl_type;

   // sign-magnitude word to 32-bit two's complement
   function automatic logic [31:0] sm_to_acc(input logic [15:0] w);
      logic [31:0] mag;
      mag = {17'd0, w[14:0]};
      return w[15] ? (32'd0 - mag) : mag;
   endfunction

   // 32-bit two's complement to sign plus low 15 bits of magnitude
   function automatic logic [15:0] acc_to_sm(input logic [31:0] v);
      logic [31:0] mag;
      mag = v[31] ? (32'd0 - v) : v;
      return {v[31], mag[14:0]};
   endfunction

endpackage

/* sv/accumulator_machine_execute_top.sv */
// top level of the accumulator machine executor: sequencer, output register
// instantiates ame_mem and ame_alu; depends on ame_pkg
//
// Input beats on req_*: req_tuser selects a memory word write (0) or an
// instruction execute (1); req_tdata carries the byte address and the word.
// Each input beat yields one or more result beats on rsp_*; rsp_tlast marks
// the final one. rsp_tuser gives the kind (none, number, char, halted).
// A word write, STA, PRC, halt and no-ops finish in decode; LDA, ADD, SUB,
// MUL and PRT pass through an execute state for the registered read of the
// two memory banks that hold a word. PRS does a separate read of the banks
// for every byte of the string, the closing zero byte included, or stops
// at MAX_STRING characters.
// The next item is accepted once the last result sits in the output
// register, so a waiting result does not hold off the next beat.
// After reset req_tready stays low while the memory is swept to zero;
// the accumulator and halt flag clear at once.
// When the receiver stalls, the result waits in the output register and
// the sequencer waits with the next one; no result is dropped.
// MEM_BYTES must be a power of two; addresses wrap modulo MEM_BYTES.
module accumulator_machine_execute_top #(
   parameter int MEM_BYTES  = ame_pkg::MEM_BYTES_DEF,
   parameter int MAX_STRING = ame_pkg::MAX_STRING_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // mem_address[11:0], word[27:12], zero[31:28]
   input  logic [0:0]  req_tuser,   // req_type[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_value[15:0], signed
   output logic [1:0]  rsp_tuser,   // out_kind[1:0]
   output logic        rsp_tlast
);
   import ame_pkg::*;

   localparam int AW = $clog2(MEM_BYTES);
   localparam int IW = AW - 1;
   localparam int CW = $clog2(MAX_STRING + 1);

   // sequencer and latched request
   state_type     state_ff, state_in;
   req_kind_type  type_ff;
   logic [11:0]   maddr_ff;
   logic [15:0]   word_ff;
   logic          halted_ff, halted_in;

   // string walk
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [7:0]    pend_ff, pend_in;
   logic          swap_ff, swap_in;

   // final result waiting for the output register
   kind_type      hold_kind_ff, hold_kind_in;
   logic [15:0]   hold_value_ff, hold_value_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   kind_type      rsp_kind_ff;
   logic [15:0]   rsp_value_ff;
   logic          rsp_last_ff;
   logic          rsp_load;
   kind_type      rsp_kind_sel;
   logic [15:0]   rsp_value_sel;
   logic          rsp_last_sel;
   logic          out_free;

   // final result request
   logic          fin;
   kind_type      fin_kind;
   logic [15:0]   fin_value;

   // memory and accumulator
   mem_ctl_type   mem_ctl;
   alu_ctl_type   alu_ctl;
   logic [11:0]   addr12;
   logic [AW-1:0] wa, wb;
   logic [IW-1:0] idx_even, idx_odd;
   logic [15:0]   wr_word;
   logic [7:0]    wdata_even, wdata_odd;
   logic [7:0]    rdata_even, rdata_odd;
   logic          mem_busy;
   logic [15:0]   rd_word;
   logic [7:0]    rd_byte;
   logic [31:0]   operand;
   logic [15:0]   store_word;
   opcode_type    op;

   assign op         = opcode_type'(word_ff[15:12]);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !mem_busy;

   // word and byte from the banks, high byte first
   assign rd_word = swap_ff ? {rdata_odd, rdata_even} : {rdata_even, rdata_odd};
   assign rd_byte = swap_ff ? rdata_odd : rdata_even;

   // bank indexes for a word at wa, wa+1 or a byte at wa
   assign wa       = addr12[AW-1:0];
   assign wb       = wa + AW'(1);
   assign idx_odd  = wa[AW-1:1];
   assign idx_even = wa[0] ? wb[AW-1:1] : wa[AW-1:1];
   assign wdata_even = wa[0] ? wr_word[7:0]  : wr_word[15:8];
   assign wdata_odd  = wa[0] ? wr_word[15:8] : wr_word[7:0];

   // next state and outputs of the sequencer
   always_comb begin
      state_in      = state_ff;
      halted_in     = halted_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      swap_in       = swap_ff;
      hold_kind_in  = hold_kind_ff;
      hold_value_in = hold_value_ff;
      rsp_load      = 1'b0;
      rsp_kind_sel  = KIND_NONE;
      rsp_value_sel = 16'd0;
      rsp_last_sel  = 1'b1;
      fin           = 1'b0;
      fin_kind      = KIND_NONE;
      fin_value     = 16'd0;
      mem_ctl       = '0;
      alu_ctl       = '0;
      addr12        = (type_ff == REQ_WRITE) ? maddr_ff : word_ff[11:0];
      wr_word       = (type_ff == REQ_WRITE) ? word_ff : store_word;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (type_ff == REQ_WRITE) begin
               mem_ctl.we_even = 1'b1;
               mem_ctl.we_odd  = 1'b1;
               fin             = 1'b1;
            end else if (halted_ff || word_ff == HALT_WORD) begin
               halted_in = 1'b1;
               fin       = 1'b1;
               fin_kind  = KIND_HALT;
            end else begin
               unique case (op)
                  OP_LDA, OP_ADD, OP_SUB, OP_MUL, OP_PRT: begin
                     mem_ctl.rd = 1'b1;
                     swap_in    = wa[0];
                     state_in   = ST_EXEC;
                  end
                  OP_STA: begin
                     mem_ctl.we_even = 1'b1;
                     mem_ctl.we_odd  = 1'b1;
                     fin             = 1'b1;
                  end
                  OP_PRC: begin
                     fin       = 1'b1;
                     fin_kind  = KIND_CHAR;
                     fin_value = {8'd0, word_ff[7:0]};
                  end
                  OP_PRS: begin
                     ptr_in        = wa;
                     cnt_in        = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_STR_RD;
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         ST_EXEC: begin
            alu_ctl.ld  = (op == OP_LDA);
            alu_ctl.add = (op == OP_ADD);
            alu_ctl.sub = (op == OP_SUB);
            alu_ctl.mul = (op == OP_MUL);
            fin         = 1'b1;
            if (op == OP_PRT) begin
               fin_kind  = KIND_NUM;
               fin_value = operand[15:0];
            end
         end
         ST_STR_RD: begin
            addr12 = 12'(ptr_ff);
            if (cnt_ff == CW'(MAX_STRING)) begin
               // length limit reached: the pending character is the last
               fin       = 1'b1;
               fin_kind  = KIND_CHAR;
               fin_value = {8'd0, pend_ff};
            end else begin
               mem_ctl.rd = 1'b1;
               swap_in    = ptr_ff[0];
               state_in   = ST_STR_CHK;
            end
         end
         ST_STR_CHK: begin
            if (rd_byte == 8'd0) begin
               fin = 1'b1;
               if (pend_valid_ff) begin
                  fin_kind  = KIND_CHAR;
                  fin_value = {8'd0, pend_ff};
               end
            end else if (!pend_valid_ff || out_free) begin
               // send the earlier character, keep this one pending
               if (pend_valid_ff) begin
                  rsp_load      = 1'b1;
                  rsp_kind_sel  = KIND_CHAR;
                  rsp_value_sel = {8'd0, pend_ff};
                  rsp_last_sel  = 1'b0;
               end
               pend_in       = rd_byte;
               pend_valid_in = 1'b1;
               cnt_in        = cnt_ff + CW'(1);
               ptr_in        = ptr_ff + AW'(1);
               state_in      = ST_STR_RD;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_kind_sel  = hold_kind_ff;
               rsp_value_sel = hold_value_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // final result goes straight out or waits in the hold register
      if (fin) begin
         if (out_free) begin
            rsp_load      = 1'b1;
            rsp_kind_sel  = fin_kind;
            rsp_value_sel = fin_value;
            rsp_last_sel  = 1'b1;
            state_in      = ST_IDLE;
         end else begin
            hold_kind_in  = fin_kind;
            hold_value_in = fin_value;
            state_in      = ST_EMIT;
         end
      end
   end

   // output register valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         halted_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         halted_ff     <= halted_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         type_ff  <= req_kind_type'(req_tuser[0]);
         maddr_ff <= req_tdata[11:0];
         word_ff  <= req_tdata[27:12];
      end
      ptr_ff        <= ptr_in;
      pend_ff       <= pend_in;
      swap_ff       <= swap_in;
      hold_kind_ff  <= hold_kind_in;
      hold_value_ff <= hold_value_in;
      if (rsp_load) begin
         rsp_kind_ff  <= rsp_kind_sel;
         rsp_value_ff <= rsp_value_sel;
         rsp_last_ff  <= rsp_last_sel;
      end
   end

   // memory banks
   ame_mem #(
      .MEM_BYTES (MEM_BYTES)
   ) u_mem (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mem_ctl),
      .idx_even   (idx_even),
      .idx_odd    (idx_odd),
      .wdata_even (wdata_even),
      .wdata_odd  (wdata_odd),
      .rdata_even (rdata_even),
      .rdata_odd  (rdata_odd),
      .busy       (mem_busy)
   );

   // accumulator
   ame_alu u_alu (
      .clock      (clock),
      .reset      (reset),
      .ctl        (alu_ctl),
      .mem_word   (rd_word),
      .operand    (operand),
      .store_word (store_word)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // an accepted beat always moves the sequencer to decode
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_DECODE))
      else $error("accepted beat did not reach decode");

   // the memory is never read and written in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.rd && (mem_ctl.we_even || mem_ctl.we_odd)))
      else $error("memory read and write overlap");

   // string count stays within the limit
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_STRING))
      else $error("string count beyond limit");

   // once halted, the machine stays halted
   assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared");

endmodule

/* sv/ame_mem.sv */
// byte memory split in an even and an odd bank, registered read
// clears both banks after reset in a sweep; depends on ame_pkg
module ame_mem #(
   parameter int MEM_BYTES = ame_pkg::MEM_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ame_pkg::mem_ctl_type             ctl,
   input  logic [$clog2(MEM_BYTES)-2:0]     idx_even,
   input  logic [$clog2(MEM_BYTES)-2:0]     idx_odd,
   input  logic [7:0]                       wdata_even,
   input  logic [7:0]                       wdata_odd,
   output logic [7:0]                       rdata_even,
   output logic [7:0]                       rdata_odd,
   output logic                             busy
);
   import ame_pkg::*;

   localparam int AW    = $clog2(MEM_BYTES);
   localparam int IW    = AW - 1;
   localparam int DEPTH = MEM_BYTES / 2;

   logic [7:0]    bank_even [DEPTH];
   logic [7:0]    bank_odd  [DEPTH];

   logic [IW-1:0] clr_idx_ff, clr_idx_in;
   logic          clr_busy_ff, clr_busy_in;
   logic [7:0]    rd_even_ff, rd_odd_ff;

   logic          we_e, we_o;
   logic [IW-1:0] wa_e, wa_o;
   logic [7:0]    wd_e, wd_o;

   // clear sweep walks both banks in parallel, one row a cycle
   always_comb begin
      clr_idx_in  = clr_idx_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + IW'(1);
         if (clr_idx_ff == {IW{1'b1}}) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_idx_ff  <= clr_idx_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // write port select: sweep overrides the sequencer
   always_comb begin
      if (clr_busy_ff) begin
         we_e = 1'b1;
         we_o = 1'b1;
         wa_e = clr_idx_ff;
         wa_o = clr_idx_ff;
         wd_e = 8'd0;
         wd_o = 8'd0;
      end else begin
         we_e = ctl.we_even;
         we_o = ctl.we_odd;
         wa_e = idx_even;
         wa_o = idx_odd;
         wd_e = wdata_even;
         wd_o = wdata_odd;
      end
   end

   // bank storage
   always_ff @(posedge clock) begin
      if (we_e) begin
         bank_even[wa_e] <= wd_e;
      end
      if (we_o) begin
         bank_odd[wa_o] <= wd_o;
      end
   end

   // registered read, held until the next read
   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         rd_even_ff <= bank_even[idx_even];
         rd_odd_ff  <= bank_odd[idx_odd];
      end
   end

   assign rdata_even = rd_even_ff;
   assign rdata_odd  = rd_odd_ff;
   assign busy       = clr_busy_ff;

endmodule

/* sv/ame_alu.sv */
// accumulator register with load, add, subtract and multiply of a memory word
// converts the sign-magnitude operand and the store word; depends on ame_pkg
module ame_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  ame_pkg::alu_ctl_type  ctl,
   input  logic [15:0]           mem_word,
   output logic [31:0]           operand,
   output logic [15:0]           store_word
);
   import ame_pkg::*;

   logic [31:0] acc_ff, acc_in;
   logic [31:0] opnd;

   assign opnd = sm_to_acc(mem_word);

   // accumulator update, wrapping at 32 bits
   always_comb begin
      acc_in = acc_ff;
      priority if (ctl.ld) begin
         acc_in = opnd;
      end else if (ctl.add) begin
         acc_in = acc_ff + opnd;
      end else if (ctl.sub) begin
         acc_in = acc_ff - opnd;
      end else if (ctl.mul) begin
         acc_in = acc_ff * opnd;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign operand    = opnd;
   assign store_word = acc_to_sm(acc_ff);

endmodule
